>>> rtl/core/hcue_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the hi-res control change emitter core
// no dependencies

package hcue_pkg;

  // level fixed point: 2^FracBits is full scale
  localparam int FracBits  = 24;
  localparam int LevelW    = FracBits + 1;
  localparam int IncW      = 26;
  localparam int SumW      = ((LevelW + 1 > IncW) ? LevelW + 1 : IncW) + 1;
  localparam int ScaledW   = LevelW + 16;
  localparam int RoomW     = 3;

  localparam logic [LevelW-1:0]  LevelFull  = {1'b1, {FracBits{1'b0}}};
  localparam logic [ScaledW-1:0] ScaledHalf = {{(ScaledW-FracBits){1'b0}},
                                               1'b1, {(FracBits-1){1'b0}}};

  // queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgUmpGroup  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMidiChan  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCtrlNum   = 2'd2;

  // message codes
  localparam logic [3:0] MtMidi1Cv  = 4'h2;
  localparam logic [3:0] MtMidi2Cv  = 4'h4;
  localparam logic [3:0] StatusCc   = 4'hB;
  localparam logic [6:0] CcLsbOffset = 7'h20;
  localparam logic [31:0] WideNone   = 32'hFFFF_FFFF;
  localparam logic [15:0] NarrowNone = 16'hFFFF;

  typedef struct packed {
    logic [3:0] group_id;
    logic [3:0] midi_channel;
    logic [6:0] controller_number;
  } hcue_cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              link_up;
    logic              wide_mode;
    logic [RoomW-1:0]  free_words;
  } hcue_item_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_word;
  } hcue_word_t;

  typedef struct packed {
    logic             valid;
    logic             full;
    logic [QCntW-1:0] count;
  } hcue_qstat_t;

  typedef struct packed {
    logic pend_valid;
  } hcue_bstat_t;

endpackage

>>> rtl/core/hcue_fifo.sv
`timescale 1ns / 1ps
// short item queue between the front and back parts
// depends on hcue_pkg

module hcue_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hcue_pkg::hcue_item_t push_data_i,
  input  logic                pop_i,
  output hcue_pkg::hcue_item_t pop_data_o,
  output hcue_pkg::hcue_qstat_t stat_o
);
  import hcue_pkg::*;

  hcue_item_t       mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != QCntW'(QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.count = cnt_q;

endmodule

>>> rtl/core/hcue_front.sv
`timescale 1ns / 1ps
// front part: accepts items, accumulates and clamps the knob level
// depends on hcue_pkg

module hcue_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hcue_pkg::IncW-1:0]  increment_i,
  input  logic                       link_up_i,
  input  logic                       wide_mode_i,
  input  logic [hcue_pkg::RoomW-1:0] free_words_i,
  input  hcue_pkg::hcue_qstat_t      qstat_i,
  output logic                       push_o,
  output hcue_pkg::hcue_item_t       push_data_o
);
  import hcue_pkg::*;

  logic [LevelW-1:0]   level_q, level_d;
  logic signed [SumW-1:0] sum;
  logic                accept;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sum = $signed({{(SumW-LevelW){1'b0}}, level_q})
        + $signed({{(SumW-IncW){increment_i[IncW-1]}}, increment_i});
    if (sum[SumW-1]) begin
      level_d = '0;
    end else if (sum > $signed({{(SumW-LevelW){1'b0}}, LevelFull})) begin
      level_d = LevelFull;
    end else begin
      level_d = sum[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (accept) begin
      level_q <= level_d;
    end
  end

  assign push_o                 = accept;
  assign push_data_o.level      = level_d;
  assign push_data_o.link_up    = link_up_i;
  assign push_data_o.wide_mode  = wide_mode_i;
  assign push_data_o.free_words = free_words_i;

endmodule

>>> rtl/core/hcue_back.sv
`timescale 1ns / 1ps
// back part: rounds the level, filters repeats, builds and sends the words
// depends on hcue_pkg

module hcue_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcue_pkg::hcue_cfg_t   cfg_i,
  input  hcue_pkg::hcue_qstat_t qstat_i,
  input  hcue_pkg::hcue_item_t  item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hcue_pkg::hcue_word_t  word_o,
  output hcue_pkg::hcue_bstat_t stat_o
);
  import hcue_pkg::*;

  logic        out_valid_q, out_valid_d;
  hcue_word_t  out_q, out_d;
  logic        pend_valid_q, pend_valid_d;
  hcue_word_t  pend_q, pend_d;
  logic [31:0] last_wide_q, last_wide_d;
  logic [15:0] last_narrow_q, last_narrow_d;

  logic               out_free;
  logic [ScaledW-1:0] scaled;
  logic [15:0]        v16;
  logic [13:0]        v14;
  logic [31:0]        v32;
  logic [7:0]         status;
  hcue_word_t         wide0, wide1, narrow0, narrow1;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = qstat_i.valid && out_free && !pend_valid_q;

  // level * 65535 rounded half up
  assign scaled = {item_i.level, 16'h0000} - {16'h0000, item_i.level} + ScaledHalf;
  assign v16    = scaled[FracBits+15:FracBits];
  assign v14    = v16[15:2];
  assign v32    = {v16, v16};
  assign status = {StatusCc, cfg_i.midi_channel};

  always_comb begin
    wide0   = '{byte0: {MtMidi2Cv, cfg_i.group_id}, byte1: status,
                byte2: {1'b0, cfg_i.controller_number}, byte3: 8'h00,
                last_word: 1'b0};
    wide1   = '{byte0: v16[15:8], byte1: v16[7:0], byte2: v16[15:8],
                byte3: v16[7:0], last_word: 1'b1};
    narrow0 = '{byte0: {MtMidi1Cv, cfg_i.group_id}, byte1: status,
                byte2: {1'b0, cfg_i.controller_number}, byte3: {1'b0, v14[13:7]},
                last_word: (item_i.free_words == 3'd1)};
    narrow1 = '{byte0: {MtMidi1Cv, cfg_i.group_id}, byte1: status,
                byte2: {1'b0, cfg_i.controller_number + CcLsbOffset},
                byte3: {1'b0, v14[6:0]}, last_word: 1'b1};
  end

  always_comb begin
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    last_wide_d   = last_wide_q;
    last_narrow_d = last_narrow_q;
    if (pend_valid_q) begin
      // second word of a packet goes out right behind the first
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end
    end else if (pop_o && item_i.link_up) begin
      if (item_i.wide_mode) begin
        if (v32 != last_wide_q) begin
          last_wide_d   = v32;
          last_narrow_d = NarrowNone;
          if (item_i.free_words >= 3'd2) begin
            out_valid_d  = 1'b1;
            out_d        = wide0;
            pend_valid_d = 1'b1;
            pend_d       = wide1;
          end
        end
      end else begin
        if ({2'b00, v14} != last_narrow_q) begin
          last_narrow_d = {2'b00, v14};
          last_wide_d   = WideNone;
          if (item_i.free_words != 3'd0) begin
            out_valid_d = 1'b1;
            out_d       = narrow0;
          end
          if (item_i.free_words >= 3'd2) begin
            pend_valid_d = 1'b1;
            pend_d       = narrow1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      pend_valid_q  <= 1'b0;
      last_wide_q   <= WideNone;
      last_narrow_q <= NarrowNone;
    end else begin
      out_valid_q   <= out_valid_d;
      pend_valid_q  <= pend_valid_d;
      last_wide_q   <= last_wide_d;
      last_narrow_q <= last_narrow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o       = out_valid_q;
  assign word_o            = out_q;
  assign stat_o.pend_valid = pend_valid_q;

endmodule

>>> rtl/core/hires_cc_ump_emitter_core.sv
`timescale 1ns / 1ps
// channel      | handshake              | payload
// input item   | in_valid_i / in_ready_o | increment_i link_up_i wide_mode_i free_words_i
// result word  | out_valid_o / out_ready_i | byte0_o..byte3_o last_word_o
// config write | cfg_we_i                | cfg_idx_i cfg_wdata_i
//
// an item is taken every cycle while the two-entry queue has room; the back
// part emits one word per cycle through its output register while the
// output is not stalled, and an item that sends a two-word packet holds the
// back part until its second word has moved into the output register. the
// first word passes through the queue and the output register. reset clears
// level, queue and last values. output stalls back up through the queue to in_ready_o.
// top level of the hi-res control change emitter; depends on hcue_pkg,
// hcue_front, hcue_fifo, hcue_back

module hires_cc_ump_emitter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcue_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcue_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hcue_pkg::IncW-1:0]     increment_i,
  input  logic                          link_up_i,
  input  logic                          wide_mode_i,
  input  logic [hcue_pkg::RoomW-1:0]    free_words_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    byte0_o,
  output logic [7:0]                    byte1_o,
  output logic [7:0]                    byte2_o,
  output logic [7:0]                    byte3_o,
  output logic                          last_word_o
);
  import hcue_pkg::*;

  hcue_cfg_t   cfg_q;
  hcue_qstat_t qstat;
  hcue_bstat_t bstat;
  hcue_item_t  push_data, head;
  hcue_word_t  word;
  logic        push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_id          <= 4'd0;
      cfg_q.midi_channel      <= 4'd0;
      cfg_q.controller_number <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUmpGroup: cfg_q.group_id          <= cfg_wdata_i[3:0];
        CfgMidiChan: cfg_q.midi_channel      <= cfg_wdata_i[3:0];
        CfgCtrlNum:  cfg_q.controller_number <= cfg_wdata_i[6:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  hcue_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .increment_i  (increment_i),
    .link_up_i    (link_up_i),
    .wide_mode_i  (wide_mode_i),
    .free_words_i (free_words_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  hcue_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (head),
    .stat_o      (qstat)
  );

  hcue_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .item_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (word),
    .stat_o      (bstat)
  );

  assign byte0_o     = word.byte0;
  assign byte1_o     = word.byte1;
  assign byte2_o     = word.byte2;
  assign byte3_o     = word.byte3;
  assign last_word_o = word.last_word;

  // a held second word always sits behind a visible first word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.pend_valid |-> out_valid_o)
    else $error("second word pending without first word on output");

  // a packet's words leave on consecutive transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=> out_valid_o && last_word_o)
    else $error("second word of packet did not follow");

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("item queue count out of range");

  // nothing is popped while a second word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.pend_valid |-> !pop)
    else $error("queue popped while packet incomplete");

endmodule

>>> tb/hires_cc_ump_emitter_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for hires_cc_ump_emitter_core: knob steps go in, UMP words
// come out and are checked against a level / rounding / change-filter predictor
// depends on hcue_pkg and hires_cc_ump_emitter_core

module hires_cc_ump_emitter_core_tb;
  import hcue_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare     = 2'd3;
  localparam logic [LevelW-1:0]  FullScale    = LevelW'(1) << FracBits;
  localparam int                 ItemsPerRun  = 150;
  localparam int                 RandomRuns   = 9;
  localparam int                 SettleCycles = 12;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [IncW-1:0]     increment_i;
  logic                link_up_i;
  logic                wide_mode_i;
  logic [RoomW-1:0]    free_words_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          byte0_o;
  logic [7:0]          byte1_o;
  logic [7:0]          byte2_o;
  logic [7:0]          byte3_o;
  logic                last_word_o;

  // predictor state
  logic [LevelW-1:0] knob_level;
  logic [31:0]       sent_wide_value;
  logic [15:0]       sent_narrow_value;
  logic [3:0]        cfg_group;
  logic [3:0]        cfg_channel;
  logic [6:0]        cfg_ctrl;

  hcue_word_t ump_words_due[$];

  int    in_gap_max;
  int    out_gap_max;
  int    steps_sent;
  int    words_checked;
  int    error_count;
  string word_field_names[5] = '{"byte0", "byte1", "byte2", "byte3", "last_word"};

  hires_cc_ump_emitter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .increment_i  (increment_i),
    .link_up_i    (link_up_i),
    .wide_mode_i  (wide_mode_i),
    .free_words_i (free_words_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte0_o      (byte0_o),
    .byte1_o      (byte1_o),
    .byte2_o      (byte2_o),
    .byte3_o      (byte3_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // level update, half-up rounding to 16 bits and per-mode change filter
  task automatic predict_ump_words(input logic [IncW-1:0] inc, input logic link,
                                   input logic wide, input logic [RoomW-1:0] room);
    logic signed [27:0] level_sum;
    logic [63:0]        scaled;
    logic [15:0]        v16;
    logic [13:0]        v14;
    logic [31:0]        v32;
    logic [RoomW-1:0]   room_left;
    hcue_word_t         words[2];
    int                 n;
    n = 0;
    room_left = room;
    level_sum = $signed({3'b000, knob_level}) + $signed({{2{inc[IncW-1]}}, inc});
    if (level_sum < 0) knob_level = '0;
    else if (level_sum > $signed({3'b000, FullScale})) knob_level = FullScale;
    else knob_level = level_sum[LevelW-1:0];
    if (!link) return;
    scaled = 64'(knob_level) * 64'd65535 + (64'd1 << (FracBits - 1));
    v16 = scaled[FracBits +: 16];
    if (wide) begin
      v32 = {v16, v16};
      if (v32 != sent_wide_value) begin
        if (room_left >= 2) begin
          words[0] = '{{MtMidi2Cv, cfg_group}, {StatusCc, cfg_channel},
                       {1'b0, cfg_ctrl}, 8'h00, 1'b0};
          words[1] = '{v32[31:24], v32[23:16], v32[15:8], v32[7:0], 1'b0};
          n = 2;
        end
        sent_wide_value = v32;
        sent_narrow_value = NarrowNone;
      end
    end else begin
      v14 = v16[15:2];
      if ({2'b00, v14} != sent_narrow_value) begin
        if (room_left >= 1) begin
          words[n] = '{{MtMidi1Cv, cfg_group}, {StatusCc, cfg_channel},
                       {1'b0, cfg_ctrl}, {1'b0, v14[13:7]}, 1'b0};
          n++;
          room_left--;
        end
        if (room_left >= 1) begin
          words[n] = '{{MtMidi1Cv, cfg_group}, {StatusCc, cfg_channel},
                       {1'b0, 7'(cfg_ctrl + CcLsbOffset)}, {1'b0, v14[6:0]}, 1'b0};
          n++;
        end
        sent_narrow_value = {2'b00, v14};
        sent_wide_value = WideNone;
      end
    end
    if (n > 0) words[n-1].last_word = 1'b1;
    for (int i = 0; i < n; i++) ump_words_due.push_back(words[i]);
  endtask

  // one knob step; valid is only lowered when a gap is drawn
  task automatic send_knob_step(input logic [IncW-1:0] inc, input logic link,
                                input logic wide, input logic [RoomW-1:0] room);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    increment_i  <= inc;
    link_up_i    <= link;
    wide_mode_i  <= wide;
    free_words_i <= room;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    steps_sent++;
    predict_ump_words(inc, link, wide, room);
  endtask

  // wait for every expected word, then let zero-result items leave the pipe
  task automatic drain_emitter();
    in_valid_i <= 1'b0;
    while (ump_words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // writes all registers plus the unused index, which must be ignored
  task automatic program_emitter(input logic [CfgDataW-1:0] group,
                                 input logic [CfgDataW-1:0] channel,
                                 input logic [CfgDataW-1:0] ctrl);
    logic [CfgIdxW-1:0]  idx[4];
    logic [CfgDataW-1:0] data[4];
    idx  = '{CfgUmpGroup, CfgMidiChan, CfgCtrlNum, CfgSpare};
    data = '{group, channel, ctrl, CfgDataW'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      case (idx[i])
        CfgUmpGroup: cfg_group   = data[i][3:0];
        CfgMidiChan: cfg_channel = data[i][3:0];
        CfgCtrlNum:  cfg_ctrl    = data[i][6:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_levels();
    in_gap_max  = 3;
    out_gap_max = 3;
    send_knob_step(26'd0, 1'b1, 1'b1, 3'd4);          // first wide packet
    send_knob_step(26'd0, 1'b1, 1'b1, 3'd4);          // unchanged, suppressed
    send_knob_step(26'sd16777216, 1'b1, 1'b1, 3'd4);  // full scale
    send_knob_step(26'h1FF_FFFF, 1'b1, 1'b1, 3'd4);   // clamps high, no change
    send_knob_step(26'h200_0000, 1'b1, 1'b0, 3'd4);   // clamps to zero, narrow pair
    send_knob_step(26'sd8388608, 1'b0, 1'b0, 3'd4);   // link down, level moves
    send_knob_step(26'd0, 1'b1, 1'b0, 3'd1);          // msb word only
    send_knob_step(26'sd8388608, 1'b1, 1'b0, 3'd0);   // dropped, memory updated
    send_knob_step(26'd0, 1'b1, 1'b0, 3'd7);          // ample room, unchanged
    send_knob_step(26'd0, 1'b1, 1'b1, 3'd1);          // wide memory cleared to all ones
    send_knob_step(-26'sd16777216, 1'b1, 1'b1, 3'd0); // wide dropped, memory updated
    send_knob_step(26'd0, 1'b1, 1'b1, 3'd2);
    send_knob_step(26'd1, 1'b1, 1'b1, 3'd5);          // rounds to same value
    send_knob_step(26'sd8388607, 1'b1, 1'b0, 3'd6);   // exact half, rounds up
    send_knob_step(26'd0, 1'b1, 1'b1, 3'd3);
    send_knob_step(-26'sd1, 1'b1, 1'b0, 3'd4);        // just below half
    send_knob_step(26'sd1024, 1'b1, 1'b0, 3'd4);
    send_knob_step(26'sd256, 1'b1, 1'b1, 3'd4);
    send_knob_step(26'h2AA_AAAA, 1'b1, 1'b1, 3'd4);
    send_knob_step(26'h155_5555, 1'b1, 1'b0, 3'd4);
    send_knob_step(-26'sd4096, 1'b1, 1'b0, 3'd2);
    drain_emitter();
  endtask

  task automatic test_register_extremes();
    logic [CfgDataW-1:0] ctrl_list[4];
    ctrl_list = '{7'd127, 7'd96, 7'd95, 7'd0};
    in_gap_max  = 2;
    out_gap_max = 2;
    for (int c = 0; c < 4; c++) begin
      program_emitter(c[0] ? 7'h7F : 7'h5A, c[1] ? 7'h70 : 7'h0F, ctrl_list[c]);
      send_knob_step(26'sd1048576, 1'b1, 1'b0, 3'd4);
      send_knob_step(-26'sd2097152, 1'b1, 1'b0, 3'd3);
      send_knob_step(26'sd524288, 1'b1, 1'b1, 3'd4);
      send_knob_step(26'sd65536, 1'b1, 1'b0, 3'd7);
      drain_emitter();
    end
  endtask

  task automatic test_random_traffic();
    logic [IncW-1:0]  inc;
    logic [RoomW-1:0] room;
    int               val;
    for (int run = 0; run < RandomRuns; run++) begin
      if (run == 0) program_emitter(7'h00, 7'h00, 7'h00);
      else if (run == 1) program_emitter(7'h7F, 7'h7F, 7'h7F);
      else program_emitter(CfgDataW'($urandom), CfgDataW'($urandom),
                           CfgDataW'($urandom));
      for (int k = 0; k < ItemsPerRun; k++) begin
        // stretches without gaps on either side now and then
        if (k % 40 == 0) begin
          in_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 10;
          out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 10;
        end
        case ($urandom_range(9, 0))
          0, 1, 2, 3: val = $urandom_range(131072) - 65536;
          4, 5:       val = $urandom_range(8388608) - 4194304;
          6:          val = $urandom_range(33554432) - 16777216;
          7:          val = $urandom;
          8:          val = 0;
          default:    val = $urandom_range(1024) - 512;
        endcase
        inc  = val[IncW-1:0];
        room = $urandom_range(1, 0) ? 3'd4 : RoomW'($urandom_range(7, 0));
        send_knob_step(inc, $urandom_range(9, 0) != 0, $urandom_range(1, 0), room);
      end
      drain_emitter();
    end
  endtask

  // result side: each word is taken after a drawn stall, which may be empty
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(out_gap_max, 0);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    hcue_word_t got;
    hcue_word_t want;
    logic [7:0] want_f[5];
    logic [7:0] got_f[5];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{byte0_o, byte1_o, byte2_o, byte3_o, last_word_o};
      if (ump_words_due.size() == 0) begin
        $display("%0t: word with nothing expected: %h %h %h %h last %b", $time,
                 got.byte0, got.byte1, got.byte2, got.byte3, got.last_word);
        error_count++;
      end else begin
        want = ump_words_due.pop_front();
        words_checked++;
        want_f = '{want.byte0, want.byte1, want.byte2, want.byte3, {7'd0, want.last_word}};
        got_f  = '{got.byte0, got.byte1, got.byte2, got.byte3, {7'd0, got.last_word}};
        for (int f = 0; f < 5; f++) begin
          if (got_f[f] !== want_f[f]) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time,
                     word_field_names[f], want_f[f], got_f[f]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    increment_i  <= '0;
    link_up_i    <= 1'b0;
    wide_mode_i  <= 1'b0;
    free_words_i <= '0;
    knob_level        = '0;
    sent_wide_value   = WideNone;
    sent_narrow_value = NarrowNone;
    cfg_group   = 4'd0;
    cfg_channel = 4'd0;
    cfg_ctrl    = 7'd1;
    in_gap_max    = 0;
    out_gap_max   = 0;
    steps_sent    = 0;
    words_checked = 0;
    error_count   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_levels();
    test_register_extremes();
    test_random_traffic();

    $display("covered %0d knob steps in both modes over %0d register settings,",
             steps_sent, RandomRuns + 4);
    $display("%0d output words checked, %0d errors", words_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
